// File: rtl/core/spd_pkg.sv
// Shared types and constants of the spanning tree peeling decoder.
`timescale 1ns / 1ps
package spd_pkg;
	localparam int NUM_VERTICES = 64;
	localparam int MAX_DEGREE   = 5;
	localparam int VERTEX_BITS  = 6;
	localparam int QUEUE_DEPTH  = 64;
	localparam int DEG_BITS     = $clog2(MAX_DEGREE + 1);
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = QPTR_BITS + 1;
	localparam int COUNT_BITS   = 6;
	localparam int PAIR_DEPTH   = 64;
	localparam int PAIR_BITS    = $clog2(PAIR_DEPTH);

	typedef logic [VERTEX_BITS-1:0] vertex_t;

	typedef struct packed {
		logic [DEG_BITS-1:0]          deg;
		vertex_t [MAX_DEGREE-1:0]     nb;
	} nbr_entry_t;

	localparam int NBR_BITS = $bits(nbr_entry_t);

	typedef struct packed {
		vertex_t leaf;
		vertex_t nb;
	} pair_t;

	localparam int PAIR_WORD_BITS = $bits(pair_t);

	typedef enum logic [1:0] {
		CMD_ADD_EDGE = 2'd0,
		CMD_SET_SYN  = 2'd1,
		CMD_START    = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic {
		LIST_PUSH   = 1'b0,
		LIST_REMOVE = 1'b1
	} list_op_t;

	typedef struct packed {
		logic full;
		logic deg_one;
	} list_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE_RD_V,
		S_EDGE_WR_V,
		S_EDGE_RD_U,
		S_EDGE_WR_U,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_POP,
		S_LEAF_RD,
		S_LEAF_CHK,
		S_NB_UPD,
		S_CHK_RD,
		S_CHK_EVAL,
		S_EMIT,
		S_DONE
	} state_t;
endpackage

// File: rtl/core/spd_in_if.sv
// Input channel of the peeling decoder: command words.
`timescale 1ns / 1ps
interface spd_in_if import spd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	vertex_t               vertex_u;
	vertex_t               vertex_v;
	logic                  syndrome_bit;
	logic [COUNT_BITS-1:0] peel_count;

	modport source(output valid, command, vertex_u, vertex_v, syndrome_bit, peel_count,
		input ready);
	modport sink(input valid, command, vertex_u, vertex_v, syndrome_bit, peel_count,
		output ready);
endinterface

// File: rtl/core/spd_out_if.sv
// Output channel of the peeling decoder: correction and done words.
`timescale 1ns / 1ps
interface spd_out_if import spd_pkg::*; ();
	logic    valid;
	logic    ready;
	vertex_t correction_u;
	vertex_t correction_v;
	logic    is_done;
	logic    error_flag;

	modport source(output valid, correction_u, correction_v, is_done, error_flag,
		input ready);
	modport sink(input valid, correction_u, correction_v, is_done, error_flag,
		output ready);
endinterface

// File: rtl/core/spd_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/spd_list_unit.sv
// Shared neighbor list unit: appends a vertex to a list or removes its first match.
`timescale 1ns / 1ps
module spd_list_unit import spd_pkg::*; (
	input  list_op_t   op,
	input  nbr_entry_t entry,
	input  vertex_t    who,
	output nbr_entry_t result,
	output list_stat_t stat
);
	logic                found;
	logic [DEG_BITS-1:0] idx;

	always_comb begin
		found = 1'b0;
		idx = '0;
		for (int i = 0; i < MAX_DEGREE; i++) begin
			if (!found && DEG_BITS'(i) < entry.deg && entry.nb[i] == who) begin
				found = 1'b1;
				idx = DEG_BITS'(i);
			end
		end
	end

	always_comb begin
		result = entry;
		stat.full = 1'b0;
		unique case (op)
			LIST_PUSH: begin
				if (entry.deg >= DEG_BITS'(MAX_DEGREE)) begin
					stat.full = 1'b1;
				end else begin
					result.nb[entry.deg] = who;
					result.deg = entry.deg + DEG_BITS'(1);
				end
			end
			LIST_REMOVE: begin
				if (found) begin
					// Close the gap; slots past the new degree are never read.
					for (int k = 0; k < MAX_DEGREE - 1; k++) begin
						if (DEG_BITS'(k) >= idx) begin
							result.nb[k] = entry.nb[k + 1];
						end
					end
					result.deg = entry.deg - DEG_BITS'(1);
				end
			end
			default: result = entry;
		endcase
		stat.deg_one = (result.deg == DEG_BITS'(1));
	end
endmodule

// File: rtl/core/spanning_tree_peeling_decoder.sv
// Top level of the spanning tree peeling decoder: sequencer, state and output register.
`timescale 1ns / 1ps
// One word is taken at a time. An edge word reads and writes each endpoint's neighbor
// list in turn through the one list unit; a syndrome word is stored as it is taken. A
// start word first scans the neighbor list memory for leaves, reading and checking each
// vertex in turn, then runs the peel steps (queue read, leaf list read, neighbor list
// read, neighbor list update, the update skipped for a leaf with an empty list), then
// reads and checks each recorded pair, sends a correction word for each pair that needs
// one and a final done word, plus whatever the sink stalls those words.
// All of it is bound by the single read port of the neighbor list memory. After the
// done word is taken the tree, the leaf queue and the overflow mark are cleared at once.
module spanning_tree_peeling_decoder import spd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	spd_in_if.sink    req,
	spd_out_if.source rsp
);
	state_t                 state_q, state_d;
	vertex_t                u_q, v_q, leaf_q, nb_q;
	logic [COUNT_BITS-1:0]  peel_q, iter_q;
	vertex_t                scan_q;
	logic [PAIR_BITS-1:0]   pairs_q, ci_q;
	logic [QPTR_BITS-1:0]   head_q;
	logic [QCNT_BITS-1:0]   qcount_q;
	logic                   dry_q, ovf_q;
	logic [NUM_VERTICES-1:0] syn_q, work_q, nbr_valid_q;
	vertex_t                nbr_raddr_q;
	vertex_t                out_u_q, out_v_q;
	logic                   out_done_q, out_err_q;

	vertex_t                nbr_raddr, nbr_waddr;
	logic                   nbr_we;
	logic [NBR_BITS-1:0]    nbr_rdata;
	nbr_entry_t             nbr_cur, unit_out;
	list_op_t               unit_op;
	vertex_t                unit_who;
	list_stat_t             unit_stat;
	logic                   q_push, q_full, q_pop;
	logic [QPTR_BITS-1:0]   q_raddr, q_waddr;
	logic [VERTEX_BITS-1:0] q_rdata;
	logic                   pair_we;
	logic [PAIR_WORD_BITS-1:0] pair_rdata;
	pair_t                  pair_cur;
	logic                   accept, out_take;
	logic [NUM_VERTICES-1:0] work_next;

	assign accept   = req.valid && req.ready;
	assign out_take = rsp.valid && rsp.ready;
	assign nbr_cur  = nbr_valid_q[nbr_raddr_q] ? nbr_entry_t'(nbr_rdata) : '0;
	assign pair_cur = pair_t'(pair_rdata);
	assign q_full   = (qcount_q == QCNT_BITS'(QUEUE_DEPTH));
	assign q_waddr  = head_q + qcount_q[QPTR_BITS-1:0];
	assign q_raddr  = head_q;

	spd_ram #(.WIDTH(NBR_BITS), .DEPTH(NUM_VERTICES)) u_nbr_ram (
		.clk   (clk),
		.we    (nbr_we),
		.waddr (nbr_waddr),
		.wdata (unit_out),
		.raddr (nbr_raddr),
		.rdata (nbr_rdata)
	);

	spd_ram #(.WIDTH(VERTEX_BITS), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_push && !q_full),
		.waddr (q_waddr),
		.wdata (state_q == S_SCAN_CHK ? nbr_raddr_q : nb_q),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	spd_ram #(.WIDTH(PAIR_WORD_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pairs_q),
		.wdata ({leaf_q, nb_q}),
		.raddr (ci_q),
		.rdata (pair_rdata)
	);

	spd_list_unit u_list (
		.op     (unit_op),
		.entry  (nbr_cur),
		.who    (unit_who),
		.result (unit_out),
		.stat   (unit_stat)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (req.command == CMD_ADD_EDGE) state_d = S_EDGE_RD_V;
					else if (req.command == CMD_START) state_d = S_SCAN_RD;
					else state_d = S_IDLE;
				end
			end
			S_EDGE_RD_V: state_d = S_EDGE_WR_V;
			S_EDGE_WR_V: state_d = S_EDGE_RD_U;
			S_EDGE_RD_U: state_d = S_EDGE_WR_U;
			S_EDGE_WR_U: state_d = S_IDLE;
			S_SCAN_RD:   state_d = S_SCAN_CHK;
			S_SCAN_CHK:  state_d = (scan_q == VERTEX_BITS'(NUM_VERTICES - 1)) ? S_POP : S_SCAN_RD;
			S_POP: begin
				priority if (iter_q == peel_q) state_d = S_CHK_RD;
				else if (qcount_q == '0) state_d = S_CHK_RD;
				else state_d = S_LEAF_RD;
			end
			S_LEAF_RD:   state_d = S_LEAF_CHK;
			S_LEAF_CHK:  state_d = (nbr_cur.deg == '0) ? S_POP : S_NB_UPD;
			S_NB_UPD:    state_d = S_POP;
			S_CHK_RD:    state_d = (ci_q == pairs_q) ? S_DONE : S_CHK_EVAL;
			S_CHK_EVAL:  state_d = work_q[pair_cur.leaf] ? S_EMIT : S_CHK_RD;
			S_EMIT:      state_d = rsp.ready ? S_CHK_RD : S_EMIT;
			S_DONE:      state_d = rsp.ready ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req.ready = (state_q == S_IDLE);
		rsp.valid = (state_q == S_EMIT) || (state_q == S_DONE);
		nbr_raddr = nbr_raddr_q;
		nbr_waddr = v_q;
		nbr_we    = 1'b0;
		unit_op   = LIST_PUSH;
		unit_who  = u_q;
		q_push    = 1'b0;
		q_pop     = 1'b0;
		pair_we   = 1'b0;
		unique case (state_q)
			S_EDGE_RD_V: nbr_raddr = v_q;
			S_EDGE_WR_V: begin
				nbr_we = 1'b1;
			end
			S_EDGE_RD_U: nbr_raddr = u_q;
			S_EDGE_WR_U: begin
				nbr_we    = 1'b1;
				nbr_waddr = u_q;
				unit_who  = v_q;
			end
			S_SCAN_RD:   nbr_raddr = scan_q;
			S_SCAN_CHK:  q_push = (nbr_cur.deg == DEG_BITS'(1));
			S_POP:       q_pop = (iter_q != peel_q) && (qcount_q != '0);
			S_LEAF_RD:   nbr_raddr = q_rdata;
			S_LEAF_CHK:  nbr_raddr = nbr_cur.nb[0];
			S_NB_UPD: begin
				unit_op   = LIST_REMOVE;
				unit_who  = leaf_q;
				nbr_we    = 1'b1;
				nbr_waddr = nb_q;
				pair_we   = 1'b1;
				q_push    = unit_stat.deg_one;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		work_next = work_q;
		work_next[pair_cur.leaf] = 1'b0;
		work_next[pair_cur.nb] = work_next[pair_cur.nb] ^ 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			syn_q       <= '0;
			nbr_valid_q <= '0;
			head_q      <= '0;
			qcount_q    <= '0;
			ovf_q       <= 1'b0;
			dry_q       <= 1'b0;
			iter_q      <= '0;
			pairs_q     <= '0;
			ci_q        <= '0;
			scan_q      <= '0;
		end else begin
			state_q <= state_d;
			if (accept && req.command == CMD_SET_SYN) begin
				syn_q[req.vertex_u] <= req.syndrome_bit;
			end
			if (accept && req.command == CMD_START) begin
				scan_q  <= '0;
				iter_q  <= '0;
				pairs_q <= '0;
				ci_q    <= '0;
				dry_q   <= 1'b0;
			end
			if (nbr_we) begin
				nbr_valid_q[nbr_waddr] <= 1'b1;
			end
			if (nbr_we && unit_op == LIST_PUSH && unit_stat.full) begin
				ovf_q <= 1'b1;
			end
			if (q_push) begin
				if (q_full) begin
					ovf_q <= 1'b1;
				end else begin
					qcount_q <= qcount_q + QCNT_BITS'(1);
				end
			end
			if (state_q == S_SCAN_CHK) begin
				scan_q <= scan_q + VERTEX_BITS'(1);
			end
			if (state_q == S_POP && iter_q != peel_q && qcount_q == '0) begin
				dry_q <= 1'b1;
			end
			if (q_pop) begin
				head_q   <= head_q + QPTR_BITS'(1);
				qcount_q <= qcount_q - QCNT_BITS'(1);
				iter_q   <= iter_q + COUNT_BITS'(1);
			end
			if (pair_we) begin
				pairs_q <= pairs_q + PAIR_BITS'(1);
			end
			if (state_q == S_CHK_EVAL) begin
				ci_q <= ci_q + PAIR_BITS'(1);
			end
			if (state_q == S_DONE && out_take) begin
				nbr_valid_q <= '0;
				head_q      <= '0;
				qcount_q    <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		nbr_raddr_q <= nbr_raddr;
		if (accept) begin
			u_q    <= req.vertex_u;
			v_q    <= req.vertex_v;
			peel_q <= req.peel_count;
		end
		if (accept && req.command == CMD_START) begin
			work_q <= syn_q;
		end
		if (state_q == S_LEAF_RD) begin
			leaf_q <= q_rdata;
		end
		if (state_q == S_LEAF_CHK) begin
			nb_q <= nbr_cur.nb[0];
		end
		if (state_q == S_CHK_EVAL && work_q[pair_cur.leaf]) begin
			work_q     <= work_next;
			out_u_q    <= pair_cur.leaf;
			out_v_q    <= pair_cur.nb;
			out_done_q <= 1'b0;
			out_err_q  <= 1'b0;
		end
		if (state_q == S_CHK_RD && ci_q == pairs_q) begin
			out_u_q    <= '0;
			out_v_q    <= '0;
			out_done_q <= 1'b1;
			out_err_q  <= dry_q || ovf_q;
		end
	end

	assign rsp.correction_u = out_u_q;
	assign rsp.correction_v = out_v_q;
	assign rsp.is_done      = out_done_q;
	assign rsp.error_flag   = out_err_q;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("leaf queue count beyond its depth");

	a_idle_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (qcount_q == '0 && head_q == '0))
		else $error("leaf queue not cleared between runs");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && rsp.is_done) |=> (state_q == S_IDLE && nbr_valid_q == '0))
		else $error("tree not cleared after done word");

	a_pairs_le_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK_RD) |-> (COUNT_BITS'(pairs_q) <= iter_q))
		else $error("more pairs than peel steps");
endmodule
